FILE: hdl/id_range_allocator_defines.svh
// Assertion macros for the ID range allocator.
`ifndef ID_RANGE_ALLOCATOR_DEFINES_SVH
`define ID_RANGE_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define IRA_ASSERT(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("%m: check failed");
`define IRA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`else
`define IRA_ASSERT(name, clk, rst_n, expr)
`define IRA_ASSERT_IMP(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/ira_pkg.sv
// Shared types and constants for the ID range allocator.
`timescale 1ns / 1ps

package ira_pkg;

  localparam int MAX_IDS_DEF = 64;
  localparam int CNT_W       = 7;
  localparam int ID_W        = 6;
  localparam int ST_W        = 2;
  localparam int Q_DEPTH     = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_PARA    = 2'd1;
  localparam logic [ST_W-1:0] ST_UNAVAIL = 2'd2;

  typedef enum logic [1:0] {
    OP_PARA,
    OP_ALLOC,
    OP_RELEASE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             cons;
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  start_id;
  } ira_entry_t;

  typedef enum logic {
    B_IDLE,
    B_SCAN
  } back_state_t;

endpackage

FILE: hdl/ira_front.sv
// Front end: accepts beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`include "id_range_allocator_defines.svh"

module ira_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_kind,
  input  logic [ira_pkg::CNT_W-1:0] in_count,
  input  logic                      in_consecutive,
  input  logic [ira_pkg::ID_W-1:0]  in_start_id,
  input  logic [ira_pkg::CNT_W-1:0] cap,
  input  logic                      pop,
  output logic                      q_valid,
  output ira_pkg::ira_entry_t       q_entry
);
  import ira_pkg::*;

  localparam int QW = $clog2(Q_DEPTH);
  localparam int FW = $clog2(Q_DEPTH + 1);

  ira_entry_t        entries_r [Q_DEPTH];
  logic [QW-1:0]     wr_ptr_r;
  logic [QW-1:0]     rd_ptr_r;
  logic [FW-1:0]     fill_r;
  logic [FW-1:0]     fill_nxt;
  logic              push;
  logic              rel_bad;
  logic [CNT_W:0]    rel_end;
  ira_entry_t        cls;

  assign busy    = (fill_r == FW'(Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill_r != '0);
  assign q_entry = entries_r[rd_ptr_r];

  assign rel_end = {2'b00, in_start_id} + {1'b0, in_count};
  assign rel_bad = (in_count == '0) || (in_count > cap) || (rel_end > {1'b0, cap});

  always_comb begin
    cls.cons     = in_consecutive;
    cls.count    = in_count;
    cls.start_id = in_start_id;
    if (in_kind == KIND_ALLOC) begin
      cls.op = (in_count == '0) ? OP_PARA : OP_ALLOC;
    end else begin
      cls.op = rel_bad ? OP_PARA : OP_RELEASE;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + FW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= cls;
    end
  end

  `IRA_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, fill_r != '0)
  `IRA_ASSERT(a_fill_bound, clk, rst_n, fill_r <= FW'(Q_DEPTH))

endmodule

FILE: hdl/ira_back.sv
// Back end: bitmap, allocation scan, release check and result beats.
`timescale 1ns / 1ps
`include "id_range_allocator_defines.svh"

module ira_back #(
  parameter int MAX_IDS = ira_pkg::MAX_IDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ira_pkg::CNT_W-1:0] cap,
  input  logic                      q_valid,
  input  ira_pkg::ira_entry_t       q_entry,
  output logic                      pop,
  output logic                      out_valid,
  output logic [ira_pkg::ST_W-1:0]  out_status,
  output logic [ira_pkg::ID_W-1:0]  out_run_start,
  output logic [ira_pkg::CNT_W-1:0] out_run_length,
  output logic                      out_last
);
  import ira_pkg::*;

  localparam int IW = $clog2(MAX_IDS);
  localparam logic [MAX_IDS-1:0] ONES = '1;

  back_state_t        state_r, state_nxt;
  logic [MAX_IDS-1:0] map_r, map_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               cons_r, cons_nxt;
  logic [ID_W-1:0]    rs_r, rs_nxt;
  logic [CNT_W-1:0]   rl_r, rl_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]    out_status_r, out_status_nxt;
  logic [ID_W-1:0]    out_run_start_r, out_run_start_nxt;
  logic [CNT_W-1:0]   out_run_length_r, out_run_length_nxt;
  logic               out_last_r, out_last_nxt;

  logic [CNT_W-1:0]   freesz;
  logic [MAX_IDS-1:0] rel_mask;
  logic [MAX_IDS-1:0] cons_mask;
  logic               bit_i;
  logic               scan_live;
  logic [ID_W-1:0]    s_cur;
  logic [CNT_W-1:0]   len_new;

  assign freesz    = (cap > total_r) ? (cap - total_r) : '0;
  assign rel_mask  = (~(ONES << q_entry.count)) << q_entry.start_id;
  assign bit_i     = map_r[i_r[IW-1:0]];
  assign scan_live = (i_r < cap);
  assign s_cur     = (rl_r == '0) ? i_r[ID_W-1:0] : rs_r;
  assign len_new   = rl_r + CNT_W'(1);
  assign cons_mask = (~(ONES << count_r)) << s_cur;

  always_comb begin
    state_nxt          = state_r;
    map_nxt            = map_r;
    total_nxt          = total_r;
    i_nxt              = i_r;
    left_nxt           = left_r;
    count_nxt          = count_r;
    cons_nxt           = cons_r;
    rs_nxt             = rs_r;
    rl_nxt             = rl_r;
    pop                = 1'b0;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = ST_OK;
    out_run_start_nxt  = '0;
    out_run_length_nxt = '0;
    out_last_nxt       = 1'b1;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          unique case (q_entry.op)
            OP_PARA: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_PARA;
            end
            OP_RELEASE: begin
              out_valid_nxt = 1'b1;
              if ((map_r & rel_mask) == rel_mask) begin
                map_nxt   = map_r & ~rel_mask;
                total_nxt = (total_r >= q_entry.count) ? (total_r - q_entry.count) : '0;
              end else begin
                out_status_nxt = ST_PARA;
              end
            end
            OP_ALLOC: begin
              if (q_entry.count > freesz) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_UNAVAIL;
              end else begin
                count_nxt = q_entry.count;
                cons_nxt  = q_entry.cons;
                left_nxt  = q_entry.count;
                i_nxt     = '0;
                rl_nxt    = '0;
                rs_nxt    = '0;
                state_nxt = B_SCAN;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_PARA;
            end
          endcase
        end
      end
      B_SCAN: begin
        i_nxt = i_r + CNT_W'(1);
        if (!scan_live) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_UNAVAIL;
          state_nxt      = B_IDLE;
        end else if (bit_i) begin
          rl_nxt = '0;
          if (!cons_r && (rl_r != '0)) begin
            out_valid_nxt      = 1'b1;
            out_run_start_nxt  = rs_r;
            out_run_length_nxt = rl_r;
            out_last_nxt       = 1'b0;
          end
        end else begin
          rs_nxt = s_cur;
          rl_nxt = len_new;
          if (cons_r) begin
            if (len_new >= count_r) begin
              out_valid_nxt      = 1'b1;
              out_run_start_nxt  = s_cur;
              out_run_length_nxt = count_r;
              map_nxt            = map_r | cons_mask;
              total_nxt          = total_r + count_r;
              state_nxt          = B_IDLE;
            end
          end else begin
            map_nxt[i_r[IW-1:0]] = 1'b1;
            left_nxt             = left_r - CNT_W'(1);
            if (left_r == CNT_W'(1)) begin
              out_valid_nxt      = 1'b1;
              out_run_start_nxt  = s_cur;
              out_run_length_nxt = len_new;
              total_nxt          = total_r + count_r;
              state_nxt          = B_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      map_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_r       <= map_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r              <= i_nxt;
    left_r           <= left_nxt;
    count_r          <= count_nxt;
    cons_r           <= cons_nxt;
    rs_r             <= rs_nxt;
    rl_r             <= rl_nxt;
    out_status_r     <= out_status_nxt;
    out_run_start_r  <= out_run_start_nxt;
    out_run_length_r <= out_run_length_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_run_start  = out_run_start_r;
  assign out_run_length = out_run_length_r;
  assign out_last       = out_last_r;

  `IRA_ASSERT(a_total_bound, clk, rst_n, total_r <= CNT_W'(MAX_IDS))
  `IRA_ASSERT_IMP(a_scan_bound, clk, rst_n, state_r == B_SCAN, i_r <= cap)
  `IRA_ASSERT_IMP(a_last_idle, clk, rst_n, out_valid_r && out_last_r, state_r == B_IDLE)
  `IRA_ASSERT_IMP(a_mid_scan, clk, rst_n, out_valid_r && !out_last_r, state_r == B_SCAN)
  `IRA_ASSERT_IMP(a_fail_empty, clk, rst_n, out_valid_r && (out_status_r != ST_OK),
                  (out_run_length_r == '0) && out_last_r)

endmodule

FILE: hdl/id_range_allocator.sv
// Top level of the ID range allocator: capacity register, front queue and back end.
// A release or a rejected request is written into the front queue, then taken by the idle
// back end, which registers its beat. An allocation scans the bitmap one ID per cycle: its
// runs leave while the scan goes on.
// The front queue takes new requests during a scan; the back end takes the next only when idle.
// Reset: synchronous, clears the bitmap and count, sets capacity to 64; results never stall.
`timescale 1ns / 1ps

module id_range_allocator #(
  parameter int MAX_IDS = ira_pkg::MAX_IDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_kind,
  input  logic [ira_pkg::CNT_W-1:0] in_count,
  input  logic                      in_consecutive,
  input  logic [ira_pkg::ID_W-1:0]  in_start_id,
  input  logic                      cfg_we,
  input  logic [ira_pkg::CNT_W-1:0] cfg_wdata,
  output logic                      out_valid,
  output logic [ira_pkg::ST_W-1:0]  out_status,
  output logic [ira_pkg::ID_W-1:0]  out_run_start,
  output logic [ira_pkg::CNT_W-1:0] out_run_length,
  output logic                      out_last
);
  import ira_pkg::*;

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] cap_eff;
  logic             q_valid;
  logic             pop;
  ira_entry_t       q_entry;

  assign cap_eff = (cap_r > CNT_W'(MAX_IDS)) ? CNT_W'(MAX_IDS) : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  ira_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_count       (in_count),
    .in_consecutive (in_consecutive),
    .in_start_id    (in_start_id),
    .cap            (cap_eff),
    .pop            (pop),
    .q_valid        (q_valid),
    .q_entry        (q_entry)
  );

  ira_back #(
    .MAX_IDS (MAX_IDS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cap            (cap_eff),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_run_start  (out_run_start),
    .out_run_length (out_run_length),
    .out_last       (out_last)
  );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for id_range_allocator: command driver, beat monitor, allocation model.
`timescale 1ns / 1ps

module testbench;
  import ira_pkg::*;

  localparam int SETTLE = 72;

  typedef struct {
    logic             kind;
    logic [CNT_W-1:0] count;
    logic             cons;
    logic [ID_W-1:0]  start_id;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  run_start;
    logic [CNT_W-1:0] run_length;
    logic             last;
  } grant_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_kind = 1'b0;
  logic [CNT_W-1:0] in_count = '0;
  logic             in_consecutive = 1'b0;
  logic [ID_W-1:0]  in_start_id = '0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             out_valid;
  logic [ST_W-1:0]  out_status;
  logic [ID_W-1:0]  out_run_start;
  logic [CNT_W-1:0] out_run_length;
  logic             out_last;

  request_t    req_q[$];
  grant_beat_t grant_q[$];
  request_t    drv_next;
  grant_beat_t mon_got;
  grant_beat_t mon_want;

  // allocator shadow state
  logic [63:0]      shadow_map = '0;
  logic [CNT_W-1:0] shadow_total = '0;
  logic [CNT_W-1:0] shadow_cap = CAP_RESET;

  int idle_pct = 0;
  int mismatches = 0;
  int accepted = 0;
  int beats = 0;
  int run_idx = 0;
  int max_runs = 0;
  int cap_writes = 0;

  id_range_allocator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_count      (in_count),
    .in_consecutive(in_consecutive),
    .in_start_id   (in_start_id),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_run_start (out_run_start),
    .out_run_length(out_run_length),
    .out_last      (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int eff_cap();
    return (shadow_cap > 64) ? 64 : int'(shadow_cap);
  endfunction

  function automatic logic [63:0] span_mask(input int n, input int first);
    logic [63:0] m;
    m = (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
    return m << first;
  endfunction

  task automatic expect_beat(input logic [ST_W-1:0] st, input int rs, input int rl,
                             input logic last);
    grant_beat_t b;
    b.status = st;
    b.run_start = rs[ID_W-1:0];
    b.run_length = rl[CNT_W-1:0];
    b.last = last;
    grant_q.push_back(b);
  endtask

  task automatic predict_request(input request_t r);
    int          eff;
    int          freesz;
    int          cnt;
    int          left;
    int          n;
    int          s;
    int          len;
    int          i;
    int          rs[32];
    int          rl[32];
    bit          found;
    bit          inrun;
    bit          full;
    logic [63:0] take;
    logic [63:0] m;
    eff = eff_cap();
    cnt = int'(r.count);
    take = '0;
    n = 0;
    if (r.kind == KIND_ALLOC) begin
      freesz = (eff > int'(shadow_total)) ? eff - int'(shadow_total) : 0;
      if (cnt == 0) begin
        expect_beat(ST_PARA, 0, 0, 1'b1);
        return;
      end
      if (cnt > freesz) begin
        expect_beat(ST_UNAVAIL, 0, 0, 1'b1);
        return;
      end
      if (r.cons) begin
        s = 0;
        len = 0;
        found = 0;
        for (i = 0; i < eff && !found; i++) begin
          if (shadow_map[i]) begin
            len = 0;
          end else begin
            if (len == 0) s = i;
            len++;
            if (len >= cnt) found = 1;
          end
        end
        if (!found) begin
          expect_beat(ST_UNAVAIL, 0, 0, 1'b1);
          return;
        end
        take = span_mask(cnt, s);
        rs[0] = s;
        rl[0] = cnt;
        n = 1;
      end else begin
        left = cnt;
        inrun = 0;
        full = 0;
        for (i = 0; i < eff && left != 0 && !full; i++) begin
          if (shadow_map[i]) begin
            inrun = 0;
          end else if (!inrun && n >= 32) begin
            full = 1;
          end else begin
            if (!inrun) begin
              rs[n] = i;
              rl[n] = 0;
              n++;
              inrun = 1;
            end
            rl[n-1]++;
            take[i] = 1'b1;
            left--;
          end
        end
        if (left != 0) begin
          expect_beat(ST_UNAVAIL, 0, 0, 1'b1);
          return;
        end
      end
      shadow_map = shadow_map | take;
      shadow_total = shadow_total + r.count;
      for (i = 0; i < n; i++) expect_beat(ST_OK, rs[i], rl[i], i == n - 1);
    end else begin
      if (cnt == 0 || cnt > eff || int'(r.start_id) > eff - cnt) begin
        expect_beat(ST_PARA, 0, 0, 1'b1);
        return;
      end
      m = span_mask(cnt, int'(r.start_id));
      if ((shadow_map & m) != m) begin
        expect_beat(ST_PARA, 0, 0, 1'b1);
        return;
      end
      shadow_map = shadow_map & ~m;
      shadow_total = (shadow_total >= r.count) ? shadow_total - r.count : '0;
      expect_beat(ST_OK, 0, 0, 1'b1);
    end
  endtask

  // driver: one command beat per start/!busy edge
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        predict_request('{in_kind, in_count, in_consecutive, in_start_id});
        accepted++;
      end
      if (req_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        drv_next = req_q.pop_front();
        start <= 1'b1;
        in_kind <= drv_next.kind;
        in_count <= drv_next.count;
        in_consecutive <= drv_next.cons;
        in_start_id <= drv_next.start_id;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic log_mismatch(input string what, input grant_beat_t want, input grant_beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%t %s: exp st=%0d rs=%0d rl=%0d last=%0d got st=%0d rs=%0d rl=%0d last=%0d",
               $realtime, what, want.status, want.run_start, want.run_length, want.last,
               got.status, got.run_start, got.run_length, got.last);
  endtask

  // monitor: results cannot be held off, check every strobed beat
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      mon_got = '{out_status, out_run_start, out_run_length, out_last};
      beats++;
      if (grant_q.size() == 0) begin
        log_mismatch("unexpected beat", '0, mon_got);
      end else begin
        mon_want = grant_q.pop_front();
        if (mon_got !== mon_want) log_mismatch("beat mismatch", mon_want, mon_got);
      end
      if (out_last === 1'b1) begin
        if (run_idx + 1 > max_runs) max_runs = run_idx + 1;
        run_idx = 0;
      end else begin
        run_idx++;
      end
    end
  end

  task automatic push_req(input logic kind, input int cnt, input logic cons, input int sid);
    request_t r;
    r.kind = kind;
    r.count = cnt[CNT_W-1:0];
    r.cons = cons;
    r.start_id = sid[ID_W-1:0];
    req_q.push_back(r);
  endtask

  task automatic wait_flushed();
    while (req_q.size() != 0 || start) @(posedge clk);
  endtask

  task automatic wait_quiet();
    while (req_q.size() != 0 || start || grant_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input int v);
    wait_quiet();
    repeat (SETTLE) @(posedge clk);
    cfg_wdata <= v[CNT_W-1:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cap = v[CNT_W-1:0];
    cap_writes++;
  endtask

  // release mostly lands on an allocated stretch; the rest is noise
  task automatic push_random();
    int eff;
    int sel;
    int r;
    int j;
    int k;
    int lo;
    int hi;
    int st;
    bit hit;
    eff = eff_cap();
    sel = $urandom_range(0, 99);
    hit = 0;
    j = 0;
    if (sel >= 45 && sel < 85 && eff > 0) begin
      r = $urandom_range(0, eff - 1);
      for (k = 0; k < eff && !hit; k++) begin
        j = (r + k) % eff;
        if (shadow_map[j]) hit = 1;
      end
    end
    if (hit) begin
      lo = j;
      while (lo > 0 && shadow_map[lo-1]) lo--;
      hi = j;
      while (hi < eff - 1 && shadow_map[hi+1]) hi++;
      st = $urandom_range(lo, j);
      push_req(KIND_RELEASE, $urandom_range(1, hi - st + 1), 1'($urandom_range(0, 1)), st);
    end else if (sel >= 85) begin
      push_req(1'($urandom_range(0, 1)), $urandom_range(0, 127), 1'($urandom_range(0, 1)),
               $urandom_range(0, 63));
    end else begin
      k = $urandom_range(0, 9);
      push_req(KIND_ALLOC,
               (k < 7) ? $urandom_range(1, 8) : (k < 9) ? $urandom_range(1, 64)
                                                         : $urandom_range(0, 127),
               1'($urandom_range(0, 1)), $urandom_range(0, 63));
    end
  endtask

  // fill everything, free the even IDs, then ask for 32 scattered IDs
  task automatic push_comb();
    int i;
    wait_flushed();
    if (shadow_total < 64) push_req(KIND_ALLOC, 64 - int'(shadow_total), 1'b0, 0);
    for (i = 0; i < 64; i += 2) push_req(KIND_RELEASE, 1, 1'b0, i);
    push_req(KIND_ALLOC, 32, 1'b0, 0);
  endtask

  task automatic run_phase(input int n, input bit comb);
    int k;
    for (k = 0; k < n; k++) begin
      if (comb && k == n / 2) push_comb();
      while (req_q.size() >= 2) @(posedge clk);
      push_random();
    end
  endtask

  int cap_plan[7]  = '{64, 5, 0, 127, 33, 2, 64};
  int idle_plan[7] = '{0, 75, 0, 6, 75, 0, 6};
  int len_plan[7]  = '{80, 60, 20, 70, 60, 30, 70};
  int p;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_capacity(64);
    push_req(KIND_ALLOC, 0, 1'b0, 0);
    push_req(KIND_ALLOC, 0, 1'b1, 0);
    push_req(KIND_RELEASE, 0, 1'b0, 0);
    push_req(KIND_ALLOC, 64, 1'b1, 0);
    push_req(KIND_ALLOC, 1, 1'b0, 0);
    push_req(KIND_RELEASE, 1, 1'b0, 63);
    push_req(KIND_RELEASE, 2, 1'b0, 63);
    push_req(KIND_RELEASE, 1, 1'b0, 63);
    push_req(KIND_ALLOC, 1, 1'b0, 63);
    push_req(KIND_RELEASE, 64, 1'b1, 0);
    push_req(KIND_ALLOC, 127, 1'b0, 0);
    push_req(KIND_RELEASE, 127, 1'b0, 0);
    push_req(KIND_RELEASE, 5, 1'b0, 10);
    push_req(KIND_ALLOC, 16, 1'b0, 0);
    push_req(KIND_RELEASE, 4, 1'b0, 3);
    push_req(KIND_ALLOC, 5, 1'b1, 0);
    push_req(KIND_ALLOC, 6, 1'b0, 0);
    push_req(KIND_RELEASE, 2, 1'b0, 10);
    push_req(KIND_ALLOC, 42, 1'b1, 0);
    push_req(KIND_ALLOC, 43, 1'b0, 0);
    push_req(KIND_RELEASE, 64, 1'b0, 0);
    for (p = 0; p < 7; p++) begin
      write_capacity(cap_plan[p]);
      idle_pct = idle_plan[p];
      run_phase(len_plan[p], cap_plan[p] == 64);
    end
    wait_quiet();
    repeat (SETTLE) @(posedge clk);
    $display("%0d requests over %0d capacity writes, %0d beats checked", accepted, cap_writes,
             beats);
    $display("longest allocation: %0d runs; %0d mismatches", max_runs, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
